>>> sv/lrw_pkg.sv
package lrw_pkg;

  localparam int unsigned FrameDepthDef = 64;
  localparam int unsigned AddrW         = 5;
  localparam int unsigned DataW         = 32;

  localparam logic [15:0] BootReleaseDef  = 16'd500;
  localparam logic [15:0] BootReadyDef    = 16'd3000;
  localparam logic [15:0] ReplyTimeoutDef = 16'd12000;
  localparam logic [3:0]  MaxRetriesDef   = 4'd3;
  localparam logic [15:0] SilenceLimitDef = 16'd3600;

  typedef enum logic [2:0] {
    OP_TICK_MS        = 3'd0,
    OP_TICK_S         = 3'd1,
    OP_SEND_STARTED   = 3'd2,
    OP_STOP_WAIT      = 3'd3,
    OP_CLEAR_SILENCE  = 3'd4,
    OP_STORE_BYTE     = 3'd5,
    OP_MODULE_STARTED = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    REG_BOOT_RELEASE  = 3'd0,
    REG_BOOT_READY    = 3'd1,
    REG_REPLY_TIMEOUT = 3'd2,
    REG_MAX_RETRIES   = 3'd3,
    REG_SILENCE_LIMIT = 3'd4
  } reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_e;

  typedef struct packed {
    logic [15:0] boot_release;
    logic [15:0] boot_ready;
    logic [15:0] reply_timeout;
    logic [3:0]  max_retries;
    logic [15:0] silence_limit;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic [5:0] idx;
    logic       is_last;
  } cmd_t;

  typedef struct packed {
    logic       reset_line;
    logic       up;
    logic       waiting;
    logic [3:0] retries;
    logic [7:0] resets;
  } status_t;

  typedef struct packed {
    logic resend;
    logic gave;
    logic stream;
  } verdict_t;

endpackage

>>> sv/lrw_supervisor.sv
module lrw_supervisor
  import lrw_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = FrameDepthDef,
  localparam int unsigned LenW = $clog2(FRAME_DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  cmd_t            cmd_i,
  input  cfg_t            cfg_i,
  output status_t         status_o,
  output verdict_t        verdict_o,
  output logic [LenW-1:0] frame_len_o
);

  logic [15:0]     ms_q, ms_d;
  logic            up_q, up_d;
  logic            wait_q, wait_d;
  logic [3:0]      ret_q, ret_d;
  logic [15:0]     sil_q, sil_d;
  logic [7:0]      rsts_q, rsts_d;
  logic            rline_q, rline_d;
  logic [LenW-1:0] len_q, len_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q    <= '0;
      up_q    <= 1'b0;
      wait_q  <= 1'b0;
      ret_q   <= '0;
      sil_q   <= '0;
      rsts_q  <= '0;
      rline_q <= 1'b0;
      len_q   <= '0;
    end else begin
      ms_q    <= ms_d;
      up_q    <= up_d;
      wait_q  <= wait_d;
      ret_q   <= ret_d;
      sil_q   <= sil_d;
      rsts_q  <= rsts_d;
      rline_q <= rline_d;
      len_q   <= len_d;
    end
  end

  always_comb begin
    ms_d      = ms_q;
    up_d      = up_q;
    wait_d    = wait_q;
    ret_d     = ret_q;
    sil_d     = sil_q;
    rsts_d    = rsts_q;
    rline_d   = rline_q;
    len_d     = len_q;
    verdict_o = '0;
    if (accept_i) begin
      unique case (cmd_i.op)
        OP_TICK_MS: begin
          if ((!up_q || wait_q) && ms_q != 16'hFFFF) ms_d = ms_q + 16'd1;
        end
        OP_TICK_S: begin
          if (sil_q != 16'hFFFF) sil_d = sil_q + 16'd1;
        end
        OP_SEND_STARTED: begin
          wait_d = 1'b1;
          ms_d   = '0;
        end
        OP_STOP_WAIT: begin
          wait_d = 1'b0;
          ms_d   = '0;
          ret_d  = '0;
        end
        OP_CLEAR_SILENCE: sil_d = '0;
        OP_STORE_BYTE: begin
          if (7'(cmd_i.idx) < 7'(FRAME_DEPTH) && cmd_i.is_last) begin
            len_d = LenW'(7'(cmd_i.idx) + 7'd1);
          end
        end
        OP_MODULE_STARTED: begin
          ms_d   = '0;
          up_d   = 1'b1;
          wait_d = 1'b0;
          len_d  = '0;
        end
        default: ;
      endcase

      if (up_d) begin
        if (ms_d >= cfg_i.reply_timeout) begin
          ms_d = '0;
          if (ret_d != 4'hF) ret_d = ret_d + 4'd1;
          if (ret_d >= cfg_i.max_retries && sil_d > cfg_i.silence_limit) begin
            up_d    = 1'b0;
            wait_d  = 1'b0;
            sil_d   = '0;
            ret_d   = '0;
            len_d   = '0;
            rsts_d  = rsts_q + 8'd1;
            rline_d = 1'b1;
          end else if (ret_d >= cfg_i.max_retries) begin
            wait_d         = 1'b0;
            ret_d          = '0;
            verdict_o.gave = 1'b1;
          end else begin
            verdict_o.resend = 1'b1;
          end
        end
      end else if (ms_d >= cfg_i.boot_ready) begin
        wait_d           = 1'b0;
        ms_d             = '0;
        ret_d            = '0;
        up_d             = 1'b1;
        verdict_o.resend = 1'b1;
      end else if (ms_d >= cfg_i.boot_release) begin
        rline_d = 1'b0;
      end
      verdict_o.stream = verdict_o.resend && (len_d != '0);
    end
  end

  assign status_o.reset_line = rline_q;
  assign status_o.up         = up_q;
  assign status_o.waiting    = wait_q;
  assign status_o.retries    = ret_q;
  assign status_o.resets     = rsts_q;
  assign frame_len_o         = len_q;

endmodule

>>> sv/link_retry_watchdog_unit.sv
// channel | direction | valid       | stall       | payload
// in      | request   | in_valid_i  | in_stall_o  | opcode, data_byte, byte_index, is_last
// out     | result    | out_valid_o | out_stall_i | resend_*, last, status, gave_up
// cfg     | APB write | psel/penable/pwrite       | paddr, pwdata, prdata
// A request without resend gives one status result; a resend streams the stored frame one
// byte per cycle while the output is not stalled, from the single frame memory read port.
// Reset clears counters and status flags, not gave_up; memory is undefined until written.
// An output stall holds the result register and blocks further requests and reads.
module link_retry_watchdog_unit
  import lrw_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = FrameDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       opcode_i,
  input  logic [7:0]       data_byte_i,
  input  logic [5:0]       byte_index_i,
  input  logic             is_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             resend_valid_o,
  output logic [7:0]       resend_byte_o,
  output logic             last_o,
  output logic             module_reset_o,
  output logic             module_up_o,
  output logic             waiting_reply_o,
  output logic [3:0]       retry_count_o,
  output logic [7:0]       reset_total_o,
  output logic             gave_up_o
);

  localparam int unsigned AW   = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int unsigned LenW = $clog2(FRAME_DEPTH + 1);

  cfg_t cfg_q, cfg_d;
  logic cfg_wr;
  reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (cfg_sel)
        REG_BOOT_RELEASE:  cfg_d.boot_release  = pwdata[15:0];
        REG_BOOT_READY:    cfg_d.boot_ready    = pwdata[15:0];
        REG_REPLY_TIMEOUT: cfg_d.reply_timeout = pwdata[15:0];
        REG_MAX_RETRIES:   cfg_d.max_retries   = pwdata[3:0];
        REG_SILENCE_LIMIT: cfg_d.silence_limit = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_BOOT_RELEASE:  prdata = DataW'(cfg_q.boot_release);
      REG_BOOT_READY:    prdata = DataW'(cfg_q.boot_ready);
      REG_REPLY_TIMEOUT: prdata = DataW'(cfg_q.reply_timeout);
      REG_MAX_RETRIES:   prdata = DataW'(cfg_q.max_retries);
      REG_SILENCE_LIMIT: prdata = DataW'(cfg_q.silence_limit);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{BootReleaseDef, BootReadyDef, ReplyTimeoutDef, MaxRetriesDef,
                 SilenceLimitDef};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  state_e          state_q, state_d;
  logic [AW-1:0]   k_q, k_d;
  logic            ov_q, ov_d;
  logic            rv_q, rv_d;
  logic            last_q, last_d;
  logic            gave_q, gave_d;
  logic [7:0]      rd_q;
  logic            rd_en;
  logic            in_acc;
  logic            wr_en;
  cmd_t            cmd;
  status_t         status;
  verdict_t        verdict;
  logic [LenW-1:0] frame_len;
  logic [7:0]      mem_q [FRAME_DEPTH];

  assign in_stall_o  = (state_q != ST_IDLE) || (ov_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cmd.op      = op_e'(opcode_i);
  assign cmd.idx     = byte_index_i;
  assign cmd.is_last = is_last_i;
  assign wr_en       = in_acc && cmd.op == OP_STORE_BYTE &&
                       7'(byte_index_i) < 7'(FRAME_DEPTH);

  lrw_supervisor #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_supervisor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .status_o    (status),
    .verdict_o   (verdict),
    .frame_len_o (frame_len)
  );

  // byte writes land at the accept edge; reads start in the following cycle at the earliest
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[byte_index_i[AW-1:0]] <= data_byte_i;
    if (rd_en) rd_q <= mem_q[k_q];
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    ov_d    = ov_q && out_stall_i;
    rv_d    = rv_q;
    last_d  = last_q;
    gave_d  = gave_q;
    rd_en   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          gave_d = verdict.gave;
          if (verdict.stream) begin
            state_d = ST_STREAM;
            k_d     = '0;
          end else begin
            ov_d   = 1'b1;
            rv_d   = 1'b0;
            last_d = 1'b1;
          end
        end
      end
      ST_STREAM: begin
        if (!ov_q || !out_stall_i) begin
          rd_en  = 1'b1;
          ov_d   = 1'b1;
          rv_d   = 1'b1;
          last_d = (LenW'(k_q) + LenW'(1)) == frame_len;
          k_d    = k_q + AW'(1);
          if (last_d) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rv_q   <= rv_d;
    last_q <= last_d;
    gave_q <= gave_d;
  end

  assign out_valid_o     = ov_q;
  assign resend_valid_o  = rv_q;
  assign resend_byte_o   = rv_q ? rd_q : 8'd0;
  assign last_o          = last_q;
  assign module_reset_o  = status.reset_line;
  assign module_up_o     = status.up;
  assign waiting_reply_o = status.waiting;
  assign retry_count_o   = status.retries;
  assign reset_total_o   = status.resets;
  assign gave_up_o       = gave_q;

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !resend_valid_o |-> last_o)
    else $error("status result without last");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o || state_q == ST_STREAM)
    else $error("accepted request produced nothing");

  a_stream_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STREAM |-> LenW'(k_q) < frame_len)
    else $error("resend index past frame length");

  a_gave_up_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gave_up_o |-> !waiting_reply_o && retry_count_o == 4'd0)
    else $error("gave up while still waiting");

endmodule
